// ===== design/srde_pkg.sv =====
// package: types, constants and helper functions of the scaled radix digit encoder
`timescale 1ns / 1ps

package srde_pkg;

  // digit limits
  localparam logic [4:0] MAX_DIGITS     = 5'd19;
  localparam logic [4:0] DEFAULT_DIGITS = 5'd4;

  // 370 days in milliseconds
  localparam logic [63:0] SPAN_MS = 64'd370 * 64'd86400000;

  // last iteration of the serial units (one bit a cycle over 64 bits)
  localparam logic [5:0] ITER_LAST = 6'd63;

  // alphabet select codes
  localparam logic [2:0] SEL_LOWER     = 3'd0;
  localparam logic [2:0] SEL_UPPER     = 3'd1;
  localparam logic [2:0] SEL_DECIMAL   = 3'd2;
  localparam logic [2:0] SEL_HEX_LOWER = 3'd3;
  localparam logic [2:0] SEL_HEX_UPPER = 3'd4;

  // input and result items
  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] value;
    logic [4:0]  digit_count;
  } srde_in_t;

  typedef struct packed {
    logic [6:0]  symbol;
    logic [4:0]  digit;
    logic        last;
    logic [34:0] step_width;
  } srde_out_t;

  // serial divider request and response
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
  } div_rsp_t;

  // serial multiplier request and response
  typedef struct packed {
    logic        start;
    logic [63:0] mcand;
    logic [63:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_WIDTH,
    ST_SCALE_DIV,
    ST_SCALE_MUL,
    ST_DIGIT,
    ST_EMIT
  } srde_state_t;

  // radix of an alphabet
  function automatic logic [4:0] radix_of(input logic [2:0] sel);
    logic [4:0] r;
    if (sel == SEL_LOWER || sel == SEL_UPPER) begin
      r = 5'd26;
    end else if (sel == SEL_DECIMAL) begin
      r = 5'd10;
    end else begin
      r = 5'd16;
    end
    return r;
  endfunction

  // largest digit count whose range fits in 64 bits
  function automatic logic [4:0] cap_of(input logic [2:0] sel);
    logic [4:0] c;
    if (sel == SEL_LOWER || sel == SEL_UPPER) begin
      c = 5'd13;
    end else if (sel == SEL_DECIMAL) begin
      c = 5'd19;
    end else begin
      c = 5'd15;
    end
    return c;
  endfunction

  // ascii symbol of a digit
  function automatic logic [6:0] symbol_of(input logic [2:0] sel, input logic [4:0] d);
    logic [6:0] s;
    logic [6:0] d7;
    d7 = {2'b00, d};
    if (sel == SEL_LOWER) begin
      s = 7'h61 + d7;
    end else if (sel == SEL_UPPER) begin
      s = 7'h41 + d7;
    end else if (d < 5'd10) begin
      s = 7'h30 + d7;
    end else if (sel == SEL_HEX_LOWER) begin
      s = 7'h61 + d7 - 7'd10;
    end else if (sel == SEL_HEX_UPPER) begin
      s = 7'h41 + d7 - 7'd10;
    end else begin
      s = 7'h30 + d7;
    end
    return s;
  endfunction

endpackage

// ===== design/scaled_radix_digit_encoder.sv =====
// top level: sequencer, digit store and output register of the scaled radix digit encoder
//
//   channel | ports                           | moves
//   --------+---------------------------------+-------------------------------------
//   input   | in_valid, in_ready, in_data     | cmd, value, digit_count
//   result  | out_valid, out_ready, out_data  | symbol, digit, last, step_width
//
// One item at a time. An item with count n digits forms the range by repeated multiplication,
// then divides for the step width, scales the value (divide or multiply), divides once per
// digit and emits n symbols; the divisions share the one-bit-a-cycle 64-bit divider.
// An item with an unknown alphabet is taken and dropped and gives no result.
// Reset is synchronous and active low and clears the sequencer and the output valid.
// A stalled result holds in the output register; the next item is taken once the last
// symbol of the current one has moved into that register.
`timescale 1ns / 1ps

module scaled_radix_digit_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srde_pkg::srde_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srde_pkg::srde_out_t out_data
);
  import srde_pkg::*;

  srde_state_t state_r, state_nxt;
  logic [2:0]  sel_r, sel_nxt;
  logic [63:0] val_r, val_nxt;
  logic [4:0]  count_r, count_nxt;
  logic [63:0] range_r, range_nxt;
  logic [4:0]  rcnt_r, rcnt_nxt;
  logic        span_ge_r, span_ge_nxt;
  logic [34:0] width_r, width_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [4:0]  digs_r [MAX_DIGITS];
  logic [4:0]  digs_nxt [MAX_DIGITS];
  srde_out_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  div_req_t    div_req;
  div_rsp_t    div_rsp;
  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;

  logic [4:0]  radix;
  logic [4:0]  req_count;
  logic [4:0]  cap;
  logic [4:0]  emit_pos;
  logic [4:0]  emit_digit;
  logic        emit_last;
  logic        out_free;

  // shared arithmetic units
  srde_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  srde_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign radix      = radix_of(sel_r);
  assign emit_pos   = count_r - 5'd1 - idx_r;
  assign emit_digit = digs_r[emit_pos];
  assign emit_last  = (idx_r == count_r - 5'd1);
  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE);

  // requested digit count, defaulted and clamped
  always_comb begin
    cap       = cap_of(in_data.cmd);
    req_count = (in_data.digit_count == 5'd0) ? DEFAULT_DIGITS : in_data.digit_count;
    if (req_count > cap) begin
      req_count = cap;
    end
    if (req_count > MAX_DIGITS) begin
      req_count = MAX_DIGITS;
    end
  end

  // sequencer next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    val_nxt       = val_r;
    count_nxt     = count_r;
    range_nxt     = range_r;
    rcnt_nxt      = rcnt_r;
    span_ge_nxt   = span_ge_r;
    width_nxt     = width_r;
    idx_nxt       = idx_r;
    digs_nxt      = digs_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_req       = '0;
    mul_req       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_data.cmd <= SEL_HEX_UPPER) begin
          sel_nxt   = in_data.cmd;
          val_nxt   = in_data.value;
          count_nxt = req_count;
          range_nxt = 64'd1;
          rcnt_nxt  = '0;
          state_nxt = ST_RANGE;
        end
      end
      // range = radix^count, one factor a cycle
      ST_RANGE: begin
        if (rcnt_r != count_r) begin
          range_nxt = 64'(range_r * {59'd0, radix});
          rcnt_nxt  = rcnt_r + 5'd1;
        end else begin
          span_ge_nxt   = (SPAN_MS >= range_r);
          div_req.start = 1'b1;
          if (SPAN_MS >= range_r) begin
            div_req.dividend = SPAN_MS;
            div_req.divisor  = range_r;
          end else begin
            div_req.dividend = range_r;
            div_req.divisor  = SPAN_MS;
          end
          state_nxt = ST_WIDTH;
        end
      end
      // step width, or the scale factor when the range exceeds the span
      ST_WIDTH: begin
        if (div_rsp.done) begin
          if (span_ge_r) begin
            width_nxt        = div_rsp.quot[34:0];
            div_req.start    = 1'b1;
            div_req.dividend = val_r;
            div_req.divisor  = div_rsp.quot;
            state_nxt        = ST_SCALE_DIV;
          end else begin
            width_nxt      = 35'd1;
            mul_req.start  = 1'b1;
            mul_req.mcand  = val_r;
            mul_req.mplier = div_rsp.quot;
            state_nxt      = ST_SCALE_MUL;
          end
        end
      end
      ST_SCALE_DIV: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quot;
          div_req.divisor  = {59'd0, radix};
          idx_nxt          = '0;
          state_nxt        = ST_DIGIT;
        end
      end
      ST_SCALE_MUL: begin
        if (mul_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = mul_rsp.prod;
          div_req.divisor  = {59'd0, radix};
          idx_nxt          = '0;
          state_nxt        = ST_DIGIT;
        end
      end
      // digits least significant first, one division each
      ST_DIGIT: begin
        if (div_rsp.done) begin
          digs_nxt[idx_r] = div_rsp.rem[4:0];
          if (idx_r == count_r - 5'd1) begin
            idx_nxt   = '0;
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt          = idx_r + 5'd1;
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quot;
            div_req.divisor  = {59'd0, radix};
          end
        end
      end
      // symbols most significant first into the output register
      ST_EMIT: begin
        if (out_free) begin
          out_nxt.symbol     = symbol_of(sel_r, emit_digit);
          out_nxt.digit      = emit_digit;
          out_nxt.last       = emit_last;
          out_nxt.step_width = width_r;
          out_valid_nxt      = 1'b1;
          idx_nxt            = idx_r + 5'd1;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sel_r     <= sel_nxt;
    val_r     <= val_nxt;
    count_r   <= count_nxt;
    range_r   <= range_nxt;
    rcnt_r    <= rcnt_nxt;
    span_ge_r <= span_ge_nxt;
    width_r   <= width_nxt;
    idx_r     <= idx_nxt;
    digs_r    <= digs_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/srde_div.sv =====
// serial restoring divider, one quotient bit a cycle
`timescale 1ns / 1ps

module srde_div (
  input  logic               clk,
  input  logic               rst_n,
  input  srde_pkg::div_req_t req,
  output srde_pkg::div_rsp_t rsp
);
  import srde_pkg::*;

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [64:0] diff;
  logic        ge;

  // one shift, compare and subtract step
  always_comb begin
    trial    = {rem_r, quo_r[63]};
    ge       = (trial >= {1'b0, dvs_r});
    diff     = trial - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[63:0] : trial[63:0];
      quo_nxt = {quo_r[62:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == ITER_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== design/srde_mul.sv =====
// serial shift-add multiplier, product modulo 2^64
`timescale 1ns / 1ps

module srde_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  srde_pkg::mul_req_t req,
  output srde_pkg::mul_rsp_t rsp
);
  import srde_pkg::*;

  logic [63:0] acc_r, acc_nxt;
  logic [63:0] mcand_r, mcand_nxt;
  logic [63:0] mplier_r, mplier_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  // one multiplier bit a cycle
  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      acc_nxt    = '0;
      mcand_nxt  = req.mcand;
      mplier_nxt = req.mplier;
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = {mcand_r[62:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[63:1]};
      cnt_nxt    = cnt_r + 6'd1;
      if (cnt_r == ITER_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule
